@@ sv/tts_pkg.sv @@
// Package for the traffic threat selector: field widths, register codes,
// reset values and angle constants. No dependencies.

package tts_pkg;

	// Field widths
	localparam int DIST_W   = 26;
	localparam int ABOVE_W  = 22;
	localparam int HEIGHT_W = 23;
	localparam int FLAGS_W  = 16;
	localparam int SPEED_W  = 16;
	localparam int ANGLE_W  = 16;
	localparam int ARR_W    = 16;
	localparam int CONE_W   = 16;
	localparam int INDEX_W  = 4;
	localparam int COUNT_W  = 5;
	localparam int CFG_W    = 26;

	// Divider: one quotient bit per cycle over the whole distance word
	localparam int DIV_STEPS  = DIST_W;
	localparam int STEP_CNT_W = $clog2(DIV_STEPS + 1);

	// Heading error arithmetic
	localparam int HEAD_W = 18;
	localparam logic [HEAD_W-1:0] FULL_TURN_CD   = HEAD_W'(36000);
	localparam logic [HEAD_W-1:0] HALF_TURN_CD   = HEAD_W'(18000);
	// three full turns less a half turn keeps course - bearing positive
	localparam logic [HEAD_W-1:0] HEADING_OFFSET = HEAD_W'(3 * 36000 - 18000);

	// Heading valid and velocity valid flags
	localparam logic [FLAGS_W-1:0] REQUIRED_FLAGS = FLAGS_W'(4 | 8);

	// Saturation limit of the nearby counter
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// Configuration register indexes
	typedef enum logic [1:0] {
		REG_MAX_DISTANCE = 2'd0,
		REG_MAX_ABOVE    = 2'd1,
		REG_MAX_ARRIVAL  = 2'd2,
		REG_CONE_WIDTH   = 2'd3
	} cfg_reg_t;

	// Register reset values
	localparam logic [DIST_W-1:0]  MAX_DISTANCE_RST = DIST_W'(67108863);
	localparam logic [ABOVE_W-1:0] MAX_ABOVE_RST    = '0;
	localparam logic [ARR_W-1:0]   MAX_ARRIVAL_RST  = ARR_W'(60);
	localparam logic [CONE_W-1:0]  CONE_WIDTH_RST   = CONE_W'(3000);

endpackage

@@ sv/tts_if.sv @@
// Request channels of the traffic threat selector: report input and result output.
// Depends on tts_pkg for field widths.

interface tts_report_if;
	import tts_pkg::*;

	logic                       valid;
	logic                       ready;
	logic                       alive;
	logic                       position_valid;
	logic [DIST_W-1:0]          distance_cm;
	logic signed [HEIGHT_W-1:0] height_above_cm;
	logic [FLAGS_W-1:0]         report_flags;
	logic [SPEED_W-1:0]         speed_cms;
	logic [ANGLE_W-1:0]         course_cd;
	logic [ANGLE_W-1:0]         bearing_cd;
	logic                       last_report;

	modport source (
		output valid, alive, position_valid, distance_cm, height_above_cm,
		       report_flags, speed_cms, course_cd, bearing_cd, last_report,
		input  ready
	);
	modport sink (
		input  valid, alive, position_valid, distance_cm, height_above_cm,
		       report_flags, speed_cms, course_cd, bearing_cd, last_report,
		output ready
	);
endinterface

interface tts_result_if;
	import tts_pkg::*;

	logic               valid;
	logic               ready;
	logic               threat_found;
	logic [INDEX_W-1:0] threat_index;
	logic [ARR_W-1:0]   arrival_seconds;
	logic [COUNT_W-1:0] nearby_count;

	modport source (
		output valid, threat_found, threat_index, arrival_seconds, nearby_count,
		input  ready
	);
	modport sink (
		input  valid, threat_found, threat_index, arrival_seconds, nearby_count,
		output ready
	);
endinterface

@@ sv/tts_div.sv @@
// Bit-serial restoring divider: distance / speed, one quotient bit per cycle.
// Depends on tts_pkg for widths and step count.

module tts_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [tts_pkg::DIST_W-1:0]      dividend,
	input  logic [tts_pkg::SPEED_W-1:0]     divisor,
	output logic                            busy,
	output logic                            last_step,
	output logic [tts_pkg::DIST_W-1:0]      quotient
);
	import tts_pkg::*;

	logic [DIST_W-1:0]     dvd_q;      // dividend bits shift out, quotient bits shift in
	logic [SPEED_W-1:0]    rem_q;
	logic [SPEED_W-1:0]    divisor_q;
	logic [STEP_CNT_W-1:0] cnt_q;

	logic [SPEED_W:0] trial;
	logic [SPEED_W:0] diff;
	logic             fits;

	// One restoring step
	assign trial = {rem_q, dvd_q[DIST_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	assign busy      = cnt_q != '0;
	assign last_step = cnt_q == STEP_CNT_W'(1);
	assign quotient  = dvd_q;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= STEP_CNT_W'(DIV_STEPS);
		end else if (busy) begin
			cnt_q <= cnt_q - STEP_CNT_W'(1);
		end
	end

	// Datapath shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q     <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy) begin
			dvd_q <= {dvd_q[DIST_W-2:0], fits};
			rem_q <= fits ? diff[SPEED_W-1:0] : trial[SPEED_W-1:0];
		end
	end

	// Each restoring step keeps the remainder below the divisor, unless the divisor is zero
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !start |-> rem_q < divisor_q || divisor_q == '0)
		else $error("divider remainder out of range");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		last_step && !start |=> !busy)
		else $error("divider ran past its last step");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy)
		else $error("divider restarted while busy");

endmodule

@@ sv/traffic_threat_selector_unit.sv @@
// Traffic threat selector top level: filters reports, times arrivals, picks the
// earliest threat per list. Depends on tts_pkg, tts_if (channels) and tts_div.
//
//  channel   dir   handshake        carries
//  reports   in    valid / ready    one aircraft report, last_report ends the list
//  results   out   valid / ready    threat summary, one per list
//  cfg       in    cfg_we           register write, cfg_idx selects, no read-back
//
// A report that needs a time of arrival passes the accept state, the bit-serial
// divider (one quotient bit per distance bit) and a decide state; other reports
// go from accept straight to decide. One report is in work at a time.
// Reset clears the list state and loads the register defaults. A result waits
// in the output register; a last report stalls in decide while it is full.

module traffic_threat_selector_unit #(
	parameter int MAX_REPORTS = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	tts_report_if.sink                reports,
	tts_result_if.source              results,
	input  logic                      cfg_we,
	input  tts_pkg::cfg_reg_t         cfg_idx,
	input  logic [tts_pkg::CFG_W-1:0] cfg_data
);
	import tts_pkg::*;

	localparam int PW = $clog2(MAX_REPORTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE   = 3'b001,
		ST_DIVIDE = 3'b010,
		ST_DECIDE = 3'b100
	} state_t;

	state_t state_q;

	// Configuration registers
	logic [DIST_W-1:0]  max_dist_q;
	logic [ABOVE_W-1:0] max_above_q;
	logic [ARR_W-1:0]   max_arr_q;
	logic [CONE_W-1:0]  cone_q;

	// List state
	logic               have_q;
	logic [ARR_W-1:0]   best_arr_q;
	logic [PW-1:0]      best_pos_q;
	logic [PW-1:0]      pos_q;
	logic [COUNT_W-1:0] within_q;

	// Current report
	logic               active_q;
	logic               near_q;
	logic               cand_q;
	logic               last_q;
	logic [HEAD_W-1:0]  hd_q;

	// Output register
	logic               out_valid_q;
	logic               out_found_q;
	logic [INDEX_W-1:0] out_index_q;
	logic [ARR_W-1:0]   out_arr_q;
	logic [COUNT_W-1:0] out_count_q;

	logic               accept;
	logic               active;
	logic               near;
	logic               cand;
	logic               div_busy;
	logic               div_last;
	logic [DIST_W-1:0]  quot;
	logic               toa_ok;
	logic [HEAD_W-1:0]  head_err;
	logic               cone_ok;
	logic               take;
	logic               out_free;
	logic               emit;
	logic               have_nx;
	logic [ARR_W-1:0]   arr_nx;
	logic [PW-1:0]      bpos_nx;
	logic [PW-1:0]      pos_nx;
	logic [COUNT_W-1:0] within_nx;
	logic [PW+INDEX_W-1:0] bpos_ext;

	assign reports.ready = state_q == ST_IDLE;
	assign accept        = reports.valid && reports.ready;

	// Filters on the incoming report
	always_comb begin
		active = pos_q < PW'(MAX_REPORTS);
		near   = active && reports.alive && reports.position_valid &&
		         reports.distance_cm <= max_dist_q;
		if (max_above_q != '0 &&
		    reports.height_above_cm > $signed({1'b0, max_above_q}))
			near = 1'b0;
		cand   = near && ((reports.report_flags & REQUIRED_FLAGS) == REQUIRED_FLAGS) &&
		         reports.speed_cms != '0;
	end

	tts_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (accept && cand),
		.dividend  (reports.distance_cm),
		.divisor   (reports.speed_cms),
		.busy      (div_busy),
		.last_step (div_last),
		.quotient  (quot)
	);

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept)
						state_q <= cand ? ST_DIVIDE : ST_DECIDE;
				end
				ST_DIVIDE: begin
					if (div_last)
						state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (!last_q || out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Report flags captured at accept
	always_ff @(posedge clk) begin
		if (accept) begin
			active_q <= active;
			near_q   <= near;
			cand_q   <= cand;
			last_q   <= reports.last_report;
		end
	end

	// Heading error: offset on accept, then fold by one turn per cycle while dividing
	always_ff @(posedge clk) begin
		if (accept)
			hd_q <= HEAD_W'(reports.course_cd) + HEADING_OFFSET - HEAD_W'(reports.bearing_cd);
		else if (state_q == ST_DIVIDE && hd_q >= FULL_TURN_CD)
			hd_q <= hd_q - FULL_TURN_CD;
	end

	// Decide: compare against limits and the best so far
	always_comb begin
		toa_ok    = quot <= DIST_W'(max_arr_q);
		head_err  = (hd_q > HALF_TURN_CD) ? FULL_TURN_CD - hd_q : hd_q;
		cone_ok   = {head_err, 1'b0} <= (HEAD_W + 1)'(cone_q);
		take      = cand_q && toa_ok && cone_ok &&
		            (!have_q || quot[ARR_W-1:0] < best_arr_q);
		have_nx   = have_q || take;
		arr_nx    = take ? quot[ARR_W-1:0] : best_arr_q;
		bpos_nx   = take ? pos_q : best_pos_q;
		pos_nx    = active_q ? pos_q + PW'(1) : pos_q;
		within_nx = (near_q && within_q != COUNT_MAX) ? within_q + COUNT_W'(1) : within_q;
		bpos_ext  = {{INDEX_W{1'b0}}, bpos_nx};
	end

	assign out_free = !out_valid_q || results.ready;
	assign emit     = state_q == ST_DECIDE && last_q && out_free;

	// List state: update per report, clear after the last one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q     <= 1'b0;
			best_arr_q <= '0;
			best_pos_q <= '0;
			pos_q      <= '0;
			within_q   <= '0;
		end else if (emit) begin
			have_q     <= 1'b0;
			best_arr_q <= '0;
			best_pos_q <= '0;
			pos_q      <= '0;
			within_q   <= '0;
		end else if (state_q == ST_DECIDE && !last_q) begin
			have_q     <= have_nx;
			best_arr_q <= arr_nx;
			best_pos_q <= bpos_nx;
			pos_q      <= pos_nx;
			within_q   <= within_nx;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			priority if (emit)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_found_q <= have_nx;
			out_index_q <= have_nx ? bpos_ext[INDEX_W-1:0] : '0;
			out_arr_q   <= have_nx ? arr_nx : '0;
			out_count_q <= within_nx;
		end
	end

	assign results.valid           = out_valid_q;
	assign results.threat_found    = out_found_q;
	assign results.threat_index    = out_index_q;
	assign results.arrival_seconds = out_arr_q;
	assign results.nearby_count    = out_count_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_dist_q  <= MAX_DISTANCE_RST;
			max_above_q <= MAX_ABOVE_RST;
			max_arr_q   <= MAX_ARRIVAL_RST;
			cone_q      <= CONE_WIDTH_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_MAX_DISTANCE: max_dist_q  <= cfg_data[DIST_W-1:0];
				REG_MAX_ABOVE:    max_above_q <= cfg_data[ABOVE_W-1:0];
				REG_MAX_ARRIVAL:  max_arr_q   <= cfg_data[ARR_W-1:0];
				REG_CONE_WIDTH:   cone_q      <= cfg_data[CONE_W-1:0];
				default:          max_dist_q  <= max_dist_q;
			endcase
		end
	end

	// Divider runs exactly while the sequencer waits on it
	a_div_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIVIDE) == div_busy)
		else $error("divider and sequencer out of step");

	// Heading fold is complete by the time a candidate is decided
	a_head_folded: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DECIDE && cand_q |-> hd_q < FULL_TURN_CD)
		else $error("heading error not reduced");

	// Nearby count never runs ahead of the report position, which stays within MAX_REPORTS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		9'(within_q) <= 9'(pos_q) && pos_q <= PW'(MAX_REPORTS))
		else $error("list counters inconsistent");

	// A result emitted leaves a cleared list behind
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> results.valid && pos_q == '0 && !have_q)
		else $error("result emit did not clear the list");

endmodule

@@ sim/traffic_threat_selector_unit_tb.sv @@
// Self-checking bench for traffic_threat_selector_unit: report lists in, threat summaries out.
// Depends on tts_pkg, tts_report_if / tts_result_if and the unit itself.
`timescale 1ns / 1ps

module traffic_threat_selector_unit_tb;
	import tts_pkg::*;

	localparam int LIST_CAP      = 16;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT   = 2000;

	typedef struct packed {
		logic                       alive;
		logic                       position_valid;
		logic [DIST_W-1:0]          distance_cm;
		logic signed [HEIGHT_W-1:0] height_above_cm;
		logic [FLAGS_W-1:0]         report_flags;
		logic [SPEED_W-1:0]         speed_cms;
		logic [ANGLE_W-1:0]         course_cd;
		logic [ANGLE_W-1:0]         bearing_cd;
		logic                       last_report;
	} report_t;

	typedef struct packed {
		logic               threat_found;
		logic [INDEX_W-1:0] threat_index;
		logic [ARR_W-1:0]   arrival_seconds;
		logic [COUNT_W-1:0] nearby_count;
	} summary_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              cfg_we;
	cfg_reg_t          cfg_idx;
	logic [CFG_W-1:0]  cfg_data;

	tts_report_if rpt_if();
	tts_result_if res_if();

	traffic_threat_selector_unit #(
		.MAX_REPORTS(LIST_CAP)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.reports(rpt_if),
		.results(res_if),
		.cfg_we(cfg_we),
		.cfg_idx(cfg_idx),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Register shadow, kept in step with every write
	logic [DIST_W-1:0]  lim_distance = MAX_DISTANCE_RST;
	logic [ABOVE_W-1:0] lim_above    = MAX_ABOVE_RST;
	logic [ARR_W-1:0]   lim_arrival  = MAX_ARRIVAL_RST;
	logic [CONE_W-1:0]  lim_cone     = CONE_WIDTH_RST;

	// List state of the threat picker
	bit                 have_best;
	int unsigned        best_arrival;
	int unsigned        best_pos;
	int                 list_pos;
	logic [COUNT_W-1:0] nearby_total;

	report_t  pending_reports[$];
	summary_t awaited_summaries[$];
	report_t  next_rpt;
	report_t  seen_rpt;
	summary_t seen_summary;
	int       loaded_count;
	int       accepted_count;
	int       mismatches;
	int       stall_cycles;
	int       gap_pct = 17;

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 200)
			$display("%0t mismatch: %s", $realtime, msg);
	endtask

	task automatic clear_list();
		have_best    = 1'b0;
		best_arrival = 0;
		best_pos     = 0;
		list_pos     = 0;
		nearby_total = '0;
	endtask

	// Walk one accepted report through the filters; a last report yields a summary
	task automatic track_report(input report_t r);
		bit          near;
		int          h;
		int unsigned toa;
		int unsigned err;
		summary_t    s;
		if (list_pos < LIST_CAP) begin
			h = {{9{r.height_above_cm[HEIGHT_W-1]}}, r.height_above_cm};
			near = r.alive && r.position_valid && r.distance_cm <= lim_distance;
			if (near && lim_above != 0 && h > int'(lim_above))
				near = 1'b0;
			if (near) begin
				if (nearby_total != COUNT_MAX)
					nearby_total++;
				if ((r.report_flags & REQUIRED_FLAGS) == REQUIRED_FLAGS && r.speed_cms != 0) begin
					toa = r.distance_cm / r.speed_cms;
					// error against the reciprocal bearing, folded to a magnitude
					err = (r.course_cd + HEADING_OFFSET - r.bearing_cd) % FULL_TURN_CD;
					if (err > HALF_TURN_CD)
						err = FULL_TURN_CD - err;
					if (toa <= lim_arrival && err * 2 <= lim_cone &&
					    (!have_best || toa < best_arrival)) begin
						have_best    = 1'b1;
						best_arrival = toa;
						best_pos     = list_pos;
					end
				end
			end
			list_pos++;
		end
		if (r.last_report) begin
			s.threat_found    = have_best;
			s.threat_index    = have_best ? best_pos[INDEX_W-1:0] : '0;
			s.arrival_seconds = have_best ? best_arrival[ARR_W-1:0] : '0;
			s.nearby_count    = nearby_total;
			awaited_summaries.push_back(s);
			clear_list();
		end
	endtask

	task automatic check_summary(input summary_t got);
		summary_t want;
		if (awaited_summaries.size() == 0) begin
			note_mismatch($sformatf("unexpected result found=%0d idx=%0d arr=%0d cnt=%0d",
				got.threat_found, got.threat_index, got.arrival_seconds, got.nearby_count));
		end else begin
			want = awaited_summaries.pop_front();
			if (got.threat_found !== want.threat_found || got.threat_index !== want.threat_index ||
			    got.arrival_seconds !== want.arrival_seconds ||
			    got.nearby_count !== want.nearby_count)
				note_mismatch($sformatf("got found=%0d idx=%0d arr=%0d cnt=%0d, want %0d/%0d/%0d/%0d",
					got.threat_found, got.threat_index, got.arrival_seconds, got.nearby_count,
					want.threat_found, want.threat_index, want.arrival_seconds,
					want.nearby_count));
		end
	endtask

	// Report driver: next request from the pending queue, random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (!rpt_if.valid || rpt_if.ready) begin
				if (pending_reports.size() > 0 && $urandom_range(0, 99) >= gap_pct) begin
					next_rpt = pending_reports.pop_front();
					rpt_if.valid           <= 1'b1;
					rpt_if.alive           <= next_rpt.alive;
					rpt_if.position_valid  <= next_rpt.position_valid;
					rpt_if.distance_cm     <= next_rpt.distance_cm;
					rpt_if.height_above_cm <= next_rpt.height_above_cm;
					rpt_if.report_flags    <= next_rpt.report_flags;
					rpt_if.speed_cms       <= next_rpt.speed_cms;
					rpt_if.course_cd       <= next_rpt.course_cd;
					rpt_if.bearing_cd      <= next_rpt.bearing_cd;
					rpt_if.last_report     <= next_rpt.last_report;
				end else begin
					rpt_if.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: predicts on accepted reports, checks accepted results, drives result ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (rpt_if.valid && rpt_if.ready) begin
				seen_rpt.alive           = rpt_if.alive;
				seen_rpt.position_valid  = rpt_if.position_valid;
				seen_rpt.distance_cm     = rpt_if.distance_cm;
				seen_rpt.height_above_cm = rpt_if.height_above_cm;
				seen_rpt.report_flags    = rpt_if.report_flags;
				seen_rpt.speed_cms       = rpt_if.speed_cms;
				seen_rpt.course_cd       = rpt_if.course_cd;
				seen_rpt.bearing_cd      = rpt_if.bearing_cd;
				seen_rpt.last_report     = rpt_if.last_report;
				track_report(seen_rpt);
				accepted_count++;
			end
			if (res_if.valid && res_if.ready) begin
				seen_summary.threat_found    = res_if.threat_found;
				seen_summary.threat_index    = res_if.threat_index;
				seen_summary.arrival_seconds = res_if.arrival_seconds;
				seen_summary.nearby_count    = res_if.nearby_count;
				check_summary(seen_summary);
			end
			if ((rpt_if.valid && rpt_if.ready) || (res_if.valid && res_if.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			res_if.ready <= ($urandom_range(0, 99) >= gap_pct);
		end
	end

	// Watchdog on handshake progress
	initial begin
		wait (stall_cycles >= STALL_LIMIT);
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic report_t mk(input bit al, input bit pv, input int unsigned dist_cm,
			input int h, input int unsigned flags, input int unsigned spd,
			input int unsigned crs, input int unsigned brg, input bit last);
		report_t r;
		r.alive           = al;
		r.position_valid  = pv;
		r.distance_cm     = dist_cm[DIST_W-1:0];
		r.height_above_cm = h[HEIGHT_W-1:0];
		r.report_flags    = flags[FLAGS_W-1:0];
		r.speed_cms       = spd[SPEED_W-1:0];
		r.course_cd       = crs[ANGLE_W-1:0];
		r.bearing_cd      = brg[ANGLE_W-1:0];
		r.last_report     = last;
		return r;
	endfunction

	// Random report: mostly aimed near the current limits, a quarter pure noise
	function automatic report_t make_report(input bit last);
		report_t     r;
		longint      d;
		int unsigned spd;
		int unsigned t;
		int          h;
		int          half;
		int          off;
		int          crs;
		int unsigned brg;
		if ($urandom_range(0, 3) == 0) begin
			r = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, last);
		end else begin
			spd = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(1, 65535);
			t = $urandom_range(0, 1) ? $urandom_range(0, 4) :
				$urandom_range(0, int'(lim_arrival) + 2);
			d = longint'(spd) * t + ((spd != 0) ? $urandom_range(0, spd - 1) :
				$urandom_range(0, 1000));
			case ($urandom_range(0, 7))
				0: d = lim_distance;
				1: d = longint'(lim_distance) + 1;
				2: d = $urandom_range(0, lim_distance);
				default: ;
			endcase
			if (d > 67108863)
				d = 67108863;
			case ($urandom_range(0, 5))
				0: h = lim_above;
				1: h = int'(lim_above) + 1;
				2: h = -int'($urandom_range(0, 4194304));
				3: h = $urandom_range(0, 4194303);
				default: h = $urandom_range(0, lim_above);
			endcase
			half = lim_cone / 2;
			case ($urandom_range(0, 5))
				0: off = half;
				1: off = -half;
				2: off = half + 1;
				3: off = int'($urandom_range(0, 36000)) - 18000;
				default: off = int'($urandom_range(0, 2 * half)) - half;
			endcase
			brg = $urandom_range(0, 35999);
			crs = ((int'(brg) + 18000 + off) % 36000 + 36000) % 36000;
			r = mk($urandom_range(0, 15) != 0, $urandom_range(0, 15) != 0, d[31:0], h,
				($urandom_range(0, 7) == 0) ? $urandom : ($urandom | REQUIRED_FLAGS),
				spd, crs, brg, last);
		end
		return r;
	endfunction

	task automatic load_report(input report_t r);
		pending_reports.push_back(r);
		loaded_count++;
	endtask

	// Whole lists of random length, some past the size bound
	task automatic load_random(input int n);
		int count;
		int len;
		count = 0;
		while (count < n) begin
			len = ($urandom_range(0, 99) < 15) ? $urandom_range(14, 22) : $urandom_range(1, 8);
			for (int i = 0; i < len; i++)
				load_report(make_report(i == len - 1));
			count += len;
		end
	endtask

	task automatic write_register(input cfg_reg_t idx, input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= value;
		case (idx)
			REG_MAX_DISTANCE: lim_distance = value[DIST_W-1:0];
			REG_MAX_ABOVE:    lim_above    = value[ABOVE_W-1:0];
			REG_MAX_ARRIVAL:  lim_arrival  = value[ARR_W-1:0];
			REG_CONE_WIDTH:   lim_cone     = value[CONE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_limits(input int unsigned dist_cm, input int unsigned above,
			input int unsigned arr, input int unsigned cone);
		write_register(REG_MAX_DISTANCE, dist_cm[CFG_W-1:0]);
		write_register(REG_MAX_ABOVE, above[CFG_W-1:0]);
		write_register(REG_MAX_ARRIVAL, arr[CFG_W-1:0]);
		write_register(REG_CONE_WIDTH, cone[CFG_W-1:0]);
	endtask

	// Sender holds off until every request is taken and every summary is back
	task automatic drain();
		while (accepted_count != loaded_count || awaited_summaries.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_idx                = REG_MAX_DISTANCE;
		cfg_data               = '0;
		rpt_if.valid           = 1'b0;
		rpt_if.alive           = 1'b0;
		rpt_if.position_valid  = 1'b0;
		rpt_if.distance_cm     = '0;
		rpt_if.height_above_cm = '0;
		rpt_if.report_flags    = '0;
		rpt_if.speed_cms       = '0;
		rpt_if.course_cd       = '0;
		rpt_if.bearing_cd      = '0;
		rpt_if.last_report     = 1'b0;
		res_if.ready           = 1'b0;
		loaded_count           = 0;
		accepted_count         = 0;
		mismatches             = 0;
		stall_cycles           = 0;
		clear_list();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Reset limits: lone dead report, then a list of edge cases
		load_report(mk(0, 1, 100, 0, 12, 1, 0, 18000, 1));
		load_report(mk(1, 0, 100, 0, 12, 1, 0, 18000, 0));
		// farthest distance, highest aircraft, arrival far too late
		load_report(mk(1, 1, 67108863, 4194303, 16'hFFFF, 65535, 0, 18000, 0));
		// arrival on the limit, heading error on the cone edge
		load_report(mk(1, 1, 600000, 0, 12, 10000, 1500, 18000, 0));
		// just outside the cone
		load_report(mk(1, 1, 590000, 0, 12, 10000, 1501, 18000, 0));
		// heading flag missing, velocity flag missing, no speed
		load_report(mk(1, 1, 590000, 0, 8, 10000, 0, 18000, 0));
		load_report(mk(1, 1, 590000, 0, 4, 10000, 0, 18000, 0));
		load_report(mk(1, 1, 0, 0, 12, 0, 0, 18000, 0));
		// error on the other side of the cone edge, earlier arrival wins
		load_report(mk(1, 1, 590000, 0, 12, 10000, 34500, 18000, 0));
		// equal arrival later in the list loses, lowest height
		load_report(mk(1, 1, 590000, -4194304, 12, 10000, 0, 18000, 0));
		// angles beyond a full turn
		load_report(mk(1, 1, 0, 0, 12, 1, 65535, 65535, 1));
		load_random(100);
		drain();

		// Height filter, distance limit edges, full cone
		set_limits(5000000, 1000, 100, 36000);
		load_report(mk(1, 1, 5000000, 1000, 12, 50000, 0, 0, 0));
		load_report(mk(1, 1, 100, 1001, 12, 1, 0, 0, 0));
		load_report(mk(1, 1, 5000001, 0, 12, 50000, 0, 0, 0));
		load_report(mk(1, 1, 100, 0, 12, 1, 0, 0, 1));
		load_report(mk(1, 1, 0, -1, 12, 65535, 9000, 0, 1));
		load_random(100);
		drain();

		// Tightest limits
		set_limits(0, 1, 0, 0);
		load_random(80);
		drain();

		// Loosest limits
		set_limits(67108863, 4194303, 65535, 36000);
		load_random(150);
		drain();

		// Random limits, no gaps on either side
		gap_pct = 0;
		set_limits($urandom_range(100000, 40000000), $urandom_range(0, 4194303),
			$urandom_range(1, 600), $urandom_range(0, 36000));
		load_random(150);
		drain();
		gap_pct = 17;

		set_limits($urandom_range(100000, 40000000), $urandom_range(1, 100000),
			$urandom_range(1, 600), $urandom_range(0, 36000));
		load_random(170);
		drain();

		if (mismatches == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

@@ traffic_threat_selector_unit.f @@
sv/tts_pkg.sv
sv/tts_if.sv
sv/tts_div.sv
sv/traffic_threat_selector_unit.sv
sim/traffic_threat_selector_unit_tb.sv
